// File: design/crfe_pkg.sv
// shared types and constants of the clipped rectangle fill engine
package crfe_pkg;

    localparam int ADDR_W  = 48;
    localparam int COORD_W = 14;
    localparam int SIZE_W  = 15;
    localparam int COLOR_W = 32;
    localparam int MASK_W  = 32;
    localparam int CFG_W   = 48;
    localparam int INDEX_W = 3;

    // largest clip limit, wide enough to hold the value itself
    localparam logic [16:0] MAX_DIMENSION = 17'd16384;

    typedef enum logic
    {
        OP_FILL = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [INDEX_W-1:0]
    {
        CFG_FRAME_BASE    = 3'd0,
        CFG_SCREEN_WIDTH  = 3'd1,
        CFG_SCREEN_HEIGHT = 3'd2,
        CFG_PITCH_PIXELS  = 3'd3,
        CFG_RED_MASK      = 3'd4,
        CFG_GREEN_MASK    = 3'd5,
        CFG_BLUE_MASK     = 3'd6
    } cfg_index_t;

    typedef struct packed
    {
        logic [COLOR_W-1:0] colour_xrgb;
        logic [SIZE_W-1:0]  rect_h;
        logic [SIZE_W-1:0]  rect_w;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] rect_x;
    } cmd_t;

    typedef struct packed
    {
        logic               last;
        logic [COLOR_W-1:0] pixel_value;
        logic [ADDR_W-1:0]  byte_address;
    } pix_t;

endpackage

// File: design/crfe_colour_conv.sv
// converts an xrgb colour into the hardware pixel layout given by the masks
module crfe_colour_conv
(
    input  logic [crfe_pkg::COLOR_W-1:0] colour_xrgb,
    input  logic [crfe_pkg::MASK_W-1:0]  red_mask,
    input  logic [crfe_pkg::MASK_W-1:0]  green_mask,
    input  logic [crfe_pkg::MASK_W-1:0]  blue_mask,
    output logic [crfe_pkg::COLOR_W-1:0] hw_colour
);

    // trailing zero count, zero for an empty mask
    function automatic logic [4:0] low_zeros(input logic [crfe_pkg::MASK_W-1:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = crfe_pkg::MASK_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

    logic [crfe_pkg::COLOR_W-1:0] red_part;
    logic [crfe_pkg::COLOR_W-1:0] green_part;
    logic [crfe_pkg::COLOR_W-1:0] blue_part;

    assign red_part   = {24'd0, colour_xrgb[23:16]} << low_zeros(red_mask);
    assign green_part = {24'd0, colour_xrgb[15:8]}  << low_zeros(green_mask);
    assign blue_part  = {24'd0, colour_xrgb[7:0]}   << low_zeros(blue_mask);
    assign hw_colour  = red_part | green_part | blue_part;

endmodule

// File: design/crfe_walker.sv
// fill state: clipping at command, row-major pixel walk at each tick
module crfe_walker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_go,
    input  logic                          tick_go,
    input  crfe_pkg::cmd_t                cmd,
    input  logic [crfe_pkg::COLOR_W-1:0]  cmd_colour,
    input  logic [crfe_pkg::ADDR_W-1:0]   frame_base,
    input  logic [crfe_pkg::SIZE_W-1:0]   screen_width,
    input  logic [crfe_pkg::SIZE_W-1:0]   screen_height,
    input  logic [crfe_pkg::SIZE_W-1:0]   pitch_pixels,
    output logic                          res_valid,
    output crfe_pkg::pix_t                res
);

    localparam int SW = crfe_pkg::SIZE_W;

    logic                          busy_reg, busy_next;
    logic [SW-1:0]                 row_reg, row_next;
    logic [SW-1:0]                 col_reg, col_next;
    logic [SW-1:0]                 first_col_reg, first_col_next;
    logic [SW-1:0]                 col_limit_reg, col_limit_next;
    logic [SW-1:0]                 row_limit_reg, row_limit_next;
    logic [crfe_pkg::ADDR_W-1:0]   row_base_reg, row_base_next;
    logic [crfe_pkg::COLOR_W-1:0]  colour_reg, colour_next;

    // min(pos + size, screen, max dimension); never above the screen value
    function automatic logic [SW-1:0] clip_limit(input logic [SW:0] sum,
                                                 input logic [SW-1:0] screen);
        logic [SW:0] m;
        m = (sum < {1'b0, screen}) ? sum : {1'b0, screen};
        if ({1'b0, m} >= crfe_pkg::MAX_DIMENSION)
        begin
            m = crfe_pkg::MAX_DIMENSION[SW:0];
        end
        return m[SW-1:0];
    endfunction

    logic [SW-1:0]                 new_col_limit;
    logic [SW-1:0]                 new_row_limit;
    logic [28:0]                   y_offset;
    logic                          row_end;
    logic                          fill_end;

    assign new_col_limit = clip_limit(SW'(cmd.rect_x) + (SW+1)'(cmd.rect_w), screen_width);
    assign new_row_limit = clip_limit(SW'(cmd.rect_y) + (SW+1)'(cmd.rect_h), screen_height);
    assign y_offset      = 29'(cmd.rect_y) * 29'(pitch_pixels);

    assign row_end  = ({1'b0, col_reg} + (SW+1)'(1)) >= {1'b0, col_limit_reg};
    assign fill_end = row_end && (({1'b0, row_reg} + (SW+1)'(1)) >= {1'b0, row_limit_reg});

    assign res_valid        = tick_go && busy_reg;
    assign res.byte_address = row_base_reg + {31'd0, col_reg, 2'b00};
    assign res.pixel_value  = colour_reg;
    assign res.last         = fill_end;

    always_comb
    begin
        busy_next      = busy_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        first_col_next = first_col_reg;
        col_limit_next = col_limit_reg;
        row_limit_next = row_limit_reg;
        row_base_next  = row_base_reg;
        colour_next    = colour_reg;
        if (cmd_go)
        begin
            colour_next    = cmd_colour;
            col_limit_next = new_col_limit;
            row_limit_next = new_row_limit;
            first_col_next = SW'(cmd.rect_x);
            col_next       = SW'(cmd.rect_x);
            row_next       = SW'(cmd.rect_y);
            row_base_next  = frame_base + {17'd0, y_offset, 2'b00};
            busy_next      = (SW'(cmd.rect_x) < new_col_limit)
                          && (SW'(cmd.rect_y) < new_row_limit);
        end
        else if (res_valid)
        begin
            if (!row_end)
            begin
                col_next = col_reg + SW'(1);
            end
            else
            begin
                col_next      = first_col_reg;
                row_next      = row_reg + SW'(1);
                row_base_next = row_base_reg + {31'd0, pitch_pixels, 2'b00};
                if (fill_end)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        first_col_reg <= first_col_next;
        col_limit_reg <= col_limit_next;
        row_limit_reg <= row_limit_next;
        row_base_reg  <= row_base_next;
        colour_reg    <= colour_next;
    end

endmodule

// File: design/crfe_out_buf.sv
// result register with one skid entry behind it
module crfe_out_buf
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  crfe_pkg::pix_t in_data,
    output logic           full,
    output logic           out_valid,
    input  logic           out_ready,
    output crfe_pkg::pix_t out_data
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    crfe_pkg::pix_t out_data_reg, out_data_next;
    crfe_pkg::pix_t skid_data_reg, skid_data_next;
    logic           pop;

    assign pop       = out_valid_reg && out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: design/clipped_rect_fill_engine_core.sv
// top level of the clipped rectangle fill engine
// a tick item's pixel write is registered in the result buffer before it shows on m_tdata
// throughput: one item per cycle while s_tready is high, commands and ticks alike; a tick during a fill gives one write
// a stalled output is absorbed by a two-entry result buffer before s_tready drops
// reset: async active low; fill goes idle, masks return to 0xff / 0xff00 / 0xff0000,
// the other configuration registers return to zero
module clipped_rect_fill_engine_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    // command and tick items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,  // rect_x, rect_y, rect_w, rect_h, colour_xrgb, zero pad
    input  logic                          s_tuser,  // op
    // pixel writes
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [79:0]                   m_tdata,  // byte_address, pixel_value
    output logic                          m_tlast,
    // register writes
    input  logic                          cfg_we,
    input  logic [crfe_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [crfe_pkg::CFG_W-1:0]    cfg_data
);

    // configuration registers
    logic [crfe_pkg::ADDR_W-1:0]  frame_base_reg;
    logic [crfe_pkg::SIZE_W-1:0]  screen_width_reg;
    logic [crfe_pkg::SIZE_W-1:0]  screen_height_reg;
    logic [crfe_pkg::SIZE_W-1:0]  pitch_pixels_reg;
    logic [crfe_pkg::MASK_W-1:0]  red_mask_reg;
    logic [crfe_pkg::MASK_W-1:0]  green_mask_reg;
    logic [crfe_pkg::MASK_W-1:0]  blue_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg    <= '0;
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
            pitch_pixels_reg  <= '0;
            red_mask_reg      <= 32'h0000_00ff;
            green_mask_reg    <= 32'h0000_ff00;
            blue_mask_reg     <= 32'h00ff_0000;
        end
        else if (cfg_we)
        begin
            unique case (crfe_pkg::cfg_index_t'(cfg_index))
                crfe_pkg::CFG_FRAME_BASE:    frame_base_reg    <= cfg_data;
                crfe_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[crfe_pkg::SIZE_W-1:0];
                crfe_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[crfe_pkg::SIZE_W-1:0];
                crfe_pkg::CFG_PITCH_PIXELS:  pitch_pixels_reg  <= cfg_data[crfe_pkg::SIZE_W-1:0];
                crfe_pkg::CFG_RED_MASK:      red_mask_reg      <= cfg_data[crfe_pkg::MASK_W-1:0];
                crfe_pkg::CFG_GREEN_MASK:    green_mask_reg    <= cfg_data[crfe_pkg::MASK_W-1:0];
                crfe_pkg::CFG_BLUE_MASK:     blue_mask_reg     <= cfg_data[crfe_pkg::MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input unpacking
    crfe_pkg::cmd_t                cmd;
    logic                          accept;
    logic                          cmd_go;
    logic                          tick_go;
    logic [crfe_pkg::COLOR_W-1:0]  hw_colour;
    logic                          res_valid;
    crfe_pkg::pix_t                res;
    crfe_pkg::pix_t                out_pix;
    logic                          buf_full;

    assign cmd     = s_tdata[89:0];
    assign accept  = s_tvalid && s_tready;
    assign cmd_go  = accept && (crfe_pkg::op_t'(s_tuser) == crfe_pkg::OP_FILL);
    assign tick_go = accept && (crfe_pkg::op_t'(s_tuser) == crfe_pkg::OP_TICK);

    // colour is converted once, at the command
    crfe_colour_conv u_colour
    (
        .colour_xrgb (cmd.colour_xrgb),
        .red_mask    (red_mask_reg),
        .green_mask  (green_mask_reg),
        .blue_mask   (blue_mask_reg),
        .hw_colour   (hw_colour)
    );

    // clip and walk; pitch is read live so a change applies from the next row
    crfe_walker u_walker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_go        (cmd_go),
        .tick_go       (tick_go),
        .cmd           (cmd),
        .cmd_colour    (hw_colour),
        .frame_base    (frame_base_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .pitch_pixels  (pitch_pixels_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // input is held off only while the skid entry is occupied
    crfe_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_pix)
    );

    assign s_tready = !buf_full;
    assign m_tdata  = {out_pix.pixel_value, out_pix.byte_address};
    assign m_tlast  = out_pix.last;

endmodule
